FILE: src/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define STQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled during reset
`define STQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/stq_pkg.sv
// types and constants of the sorted timeout queue
`default_nettype none

package stq_pkg;

    localparam int DEPTH       = 16;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 16;
    localparam int RUN_W       = $clog2(MAX_RESULTS);
    localparam int TIME_W      = 48;
    localparam int PROD_W      = 32;
    localparam int ID_W        = 8;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [15:0]       TPM_RESET = 16'd1000;

    // request codes
    localparam logic [1:0] REQ_TICK    = 2'd0;
    localparam logic [1:0] REQ_PROGRAM = 2'd1;
    localparam logic [1:0] REQ_CANCEL  = 2'd2;
    localparam logic [1:0] REQ_RSVD    = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_FIRED     = 3'd0;
    localparam logic [2:0] STAT_NONE      = 3'd1;
    localparam logic [2:0] STAT_PROGRAMED = 3'd2;
    localparam logic [2:0] STAT_CANCELLED = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [2:0] STAT_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  timer_id;
        logic [15:0] delay_ms;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] fired_id;
        logic       head_changed;
        logic       last_of_run;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0] deadline;
        logic [ID_W-1:0]   ident;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CANCEL,
        OP_POP,
        OP_INSERT
    } cell_op_t;

    // command broadcast to every cell
    typedef struct packed {
        cell_op_t          op;
        entry_t            ent;
        logic [TIME_W-1:0] now;
    } cell_cmd_t;

    // flags gathered from the cell row
    typedef struct packed {
        logic            found;
        logic            head_match;
        logic            head_here;
        logic            head_expired;
        logic            next_expired;
        logic [ID_W-1:0] head_ident;
    } cell_stat_t;

endpackage

`default_nettype wire

FILE: src/stq_cell.sv
// one table entry of the sorted row, shifting to its neighbors
`default_nettype none

module stq_cell
    import stq_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_cmd_t cmd,
    input  wire logic      occ,
    input  wire entry_t    left,
    input  wire logic      left_here,
    input  wire logic      seen_in,
    input  wire entry_t    right,
    output entry_t         ent,
    output logic           here_out,
    output logic           seen_out,
    output logic           expired
);

    entry_t ent_reg;
    entry_t ent_next;
    logic   match;

    // id match ripples right so only the first match counts
    assign match    = occ && (ent_reg.ident == cmd.ent.ident);
    assign seen_out = seen_in | match;

    // new entry goes at or before this cell (after equal deadlines)
    assign here_out = !(occ && (ent_reg.deadline <= cmd.ent.deadline));

    // entry due at the current time
    assign expired  = occ && (ent_reg.deadline <= cmd.now);

    assign ent = ent_reg;

    // next entry contents
    always_comb
    begin
        ent_next = ent_reg;
        case (cmd.op)
            OP_HOLD:
            begin
                ent_next = ent_reg;
            end
            OP_CANCEL:
            begin
                if (seen_out)
                begin
                    ent_next = right;
                end
            end
            OP_POP:
            begin
                ent_next = right;
            end
            OP_INSERT:
            begin
                if (here_out)
                begin
                    ent_next = left_here ? left : cmd.ent;
                end
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

FILE: src/stq_ctrl.sv
// request sequencer, time counter, fill count and result register
`default_nettype none

module stq_ctrl
    import stq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire req_t       req,
    output logic            rsp_valid,
    input  wire logic       rsp_stall,
    output rsp_t            rsp,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire cell_stat_t stat,
    output cell_cmd_t       cmd,
    output logic [CNT_W-1:0] count
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CANCEL = 6'b000010,
        S_ADD    = 6'b000100,
        S_INSERT = 6'b001000,
        S_TICK   = 6'b010000,
        S_FIRE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [15:0]         tpm_reg;
    req_t                req_reg, req_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [TIME_W-1:0]   dl_reg, dl_next;
    logic                head_reg, head_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg, rsp_next;
    logic                emit;
    logic                out_free;
    logic                last;
    logic [TIME_W:0]     sum;
    cell_op_t            op;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;

    assign cmd.op           = op;
    assign cmd.ent.deadline = dl_reg;
    assign cmd.ent.ident    = req_reg.timer_id;
    assign cmd.now          = time_reg;

    // deadline sum with saturation check
    assign sum  = {1'b0, time_reg} + (TIME_W + 1)'(prod_reg);

    // last fired beat of a tick run
    assign last = (run_reg == RUN_W'(MAX_RESULTS - 1)) || !stat.next_expired;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        time_next  = time_reg;
        count_next = count_reg;
        req_next   = req_reg;
        prod_next  = prod_reg;
        dl_next    = dl_reg;
        head_next  = head_reg;
        run_next   = run_reg;
        rsp_next   = rsp_reg;
        emit       = 1'b0;
        op         = OP_HOLD;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    case (req.req_type)
                        REQ_TICK:    state_next = S_TICK;
                        REQ_PROGRAM: state_next = S_CANCEL;
                        REQ_CANCEL:  state_next = S_CANCEL;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_CANCEL:
            begin
                prod_next = PROD_W'(req_reg.delay_ms) * PROD_W'(tpm_reg);
                if (req_reg.req_type == REQ_PROGRAM)
                begin
                    op = OP_CANCEL;
                    if (stat.found)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    head_next  = stat.found && stat.head_match;
                    state_next = S_ADD;
                end
                else if (out_free)
                begin
                    op   = OP_CANCEL;
                    emit = 1'b1;
                    rsp_next.fired_id    = '0;
                    rsp_next.last_of_run = 1'b1;
                    if (stat.found)
                    begin
                        count_next            = count_reg - CNT_W'(1);
                        rsp_next.status       = STAT_CANCELLED;
                        rsp_next.head_changed = stat.head_match;
                    end
                    else
                    begin
                        rsp_next.status       = STAT_NOT_FOUND;
                        rsp_next.head_changed = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_ADD:
            begin
                dl_next    = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                state_next = S_INSERT;
            end
            S_INSERT:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    rsp_next.fired_id    = '0;
                    rsp_next.last_of_run = 1'b1;
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        rsp_next.status       = STAT_FULL;
                        rsp_next.head_changed = 1'b0;
                    end
                    else
                    begin
                        op                    = OP_INSERT;
                        count_next            = count_reg + CNT_W'(1);
                        rsp_next.status       = STAT_PROGRAMED;
                        rsp_next.head_changed = head_reg | stat.head_here;
                    end
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                time_next  = (time_reg == TIME_MAX) ? time_reg : time_reg + TIME_W'(1);
                run_next   = '0;
                state_next = S_FIRE;
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    rsp_next.head_changed = 1'b0;
                    if (stat.head_expired)
                    begin
                        op                    = OP_POP;
                        count_next            = count_reg - CNT_W'(1);
                        run_next              = run_reg + RUN_W'(1);
                        rsp_next.status       = STAT_FIRED;
                        rsp_next.fired_id     = stat.head_ident;
                        rsp_next.last_of_run  = last;
                        if (last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        rsp_next.status      = STAT_NONE;
                        rsp_next.fired_id    = '0;
                        rsp_next.last_of_run = 1'b1;
                        state_next           = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            count_reg     <= '0;
            tpm_reg       <= TPM_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            time_reg  <= time_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                tpm_reg <= cfg_data;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        prod_reg <= prod_next;
        dl_reg   <= dl_next;
        head_reg <= head_next;
        run_reg  <= run_next;
        rsp_reg  <= rsp_next;
    end

endmodule

`default_nettype wire

FILE: src/sorted_timeout_queue.sv
// Sorted timeout queue: a row of deadline-sorted entry cells under one sequencer.
// A cancel registers its result from the cancel step; a program passes through the cancel,
// deadline add and insert steps; a tick advances the time, then registers its beats in turn.
// One request at a time: the input stalls until the last beat is registered, and output
// stalls hold each step that registers a result beat.
// rst_n clears the time counter, empties the table and sets ticks_per_msec to 1000.
`default_nettype none

module sorted_timeout_queue
    import stq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    cell_cmd_t        cmd;
    cell_stat_t       stat;
    logic [CNT_W-1:0] count;
    entry_t           ents [DEPTH];
    logic [DEPTH-1:0] occ;
    logic [DEPTH-1:0] here;
    logic [DEPTH-1:0] seen;
    logic [DEPTH-1:0] expired;

    // sequencer
    stq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .cmd       (cmd),
        .count     (count)
    );

    // row of entry cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        entry_t left_ent;
        entry_t right_ent;
        logic   left_here;
        logic   seen_in;

        assign occ[i] = (count > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_ent  = cmd.ent;
            assign left_here = 1'b0;
            assign seen_in   = 1'b0;
        end
        else
        begin : g_mid
            assign left_ent  = ents[i-1];
            assign left_here = here[i-1];
            assign seen_in   = seen[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_ent = cmd.ent;
        end
        else
        begin : g_inner
            assign right_ent = ents[i+1];
        end

        stq_cell u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .occ       (occ[i]),
            .left      (left_ent),
            .left_here (left_here),
            .seen_in   (seen_in),
            .right     (right_ent),
            .ent       (ents[i]),
            .here_out  (here[i]),
            .seen_out  (seen[i]),
            .expired   (expired[i])
        );
    end

    // row flags for the sequencer
    assign stat.found        = seen[DEPTH-1];
    assign stat.head_match   = seen[0];
    assign stat.head_here    = here[0];
    assign stat.head_expired = expired[0];
    assign stat.next_expired = expired[1];
    assign stat.head_ident   = ents[0].ident;

endmodule

`default_nettype wire

FILE: src/stq_checker.sv
// port-level checks of the sorted timeout queue and their binding
`default_nettype none

`include "assert_macros.svh"

module stq_checker
    import stq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    // a stalled result beat holds
    `STQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // any request that yields results keeps the block busy next cycle
    `STQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n,
        req_valid && !req_stall && (req.req_type != REQ_RSVD), req_stall)

    // only fired beats can be followed by more beats of the same run
    `STQ_ASSERT_IMPLY(a_single_last, clk, rst_n,
        rsp_valid && (rsp.status != STAT_FIRED), rsp.last_of_run)

    // head change only on successful program or cancel
    `STQ_ASSERT_IMPLY(a_head_flag, clk, rst_n, rsp_valid && rsp.head_changed,
        (rsp.status == STAT_PROGRAMED) || (rsp.status == STAT_CANCELLED))

    // fired id is zero outside fired beats
    `STQ_ASSERT_IMPLY(a_id_zero, clk, rst_n, rsp_valid && (rsp.status != STAT_FIRED),
        rsp.fired_id == '0)

endmodule

bind sorted_timeout_queue stq_checker u_stq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire
